>>> rtl/core/movem_pkg.sv
// Types and constants shared by the MOVEM transfer sequencer modules.
package movem_pkg;

  // Opcode pattern of MOVEM and field masks.
  localparam logic [15:0] MOVEM_MASK   = 16'hfb80;
  localparam logic [15:0] MOVEM_MATCH  = 16'h4880;
  localparam logic [15:0] IDX_RESERVED = 16'h0700;
  localparam logic [15:0] IDX_IS_ADDR  = 16'h8000;
  localparam logic [15:0] IDX_IS_LONG  = 16'h0800;
  localparam logic [15:0] DIR_TO_REG   = 16'h0400;
  localparam logic [15:0] SIZE_LONG    = 16'h0040;

  // Effective address modes (opcode bits 5..3).
  localparam logic [2:0] MODE_DN      = 3'd0;
  localparam logic [2:0] MODE_AN      = 3'd1;
  localparam logic [2:0] MODE_IND     = 3'd2;
  localparam logic [2:0] MODE_POSTINC = 3'd3;
  localparam logic [2:0] MODE_PREDEC  = 3'd4;
  localparam logic [2:0] MODE_D16     = 3'd5;
  localparam logic [2:0] MODE_INDEX   = 3'd6;
  localparam logic [2:0] MODE_EXT     = 3'd7;

  // Mode 7 register field.
  localparam logic [2:0] EXT_ABS_W   = 3'd0;
  localparam logic [2:0] EXT_ABS_L   = 3'd1;
  localparam logic [2:0] EXT_PC_D16  = 3'd2;
  localparam logic [2:0] EXT_PC_IDX  = 3'd3;

  // Item status codes.
  localparam logic [1:0] ST_RUN     = 2'd0;
  localparam logic [1:0] ST_ILLEGAL = 2'd1;
  localparam logic [1:0] ST_FAULT   = 2'd2;

  typedef struct packed {
    logic [15:0] opcode;
    logic [15:0] reg_mask;
    logic [15:0] ext_word1;
    logic [15:0] ext_word2;
    logic [31:0] addr_reg_value;
    logic [31:0] index_reg_value;
    logic [31:0] pc;
  } movem_in_t;

  typedef struct packed {
    logic        transfer_valid;
    logic [3:0]  reg_number;
    logic [31:0] transfer_address;
    logic        is_write;
    logic        is_long;
    logic        last;
    logic [1:0]  status;
    logic        writeback_valid;
    logic [31:0] writeback_value;
    logic [31:0] next_pc;
  } movem_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_EMIT
  } movem_state_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic emit;
  } movem_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic item_last;
  } movem_stat_t;

endpackage

>>> rtl/core/movem_ctrl.sv
// Sequencer state machine: load, address calculation, one beat per step.
module movem_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   instr_valid,
  output logic                   instr_stall,
  input  movem_pkg::movem_stat_t st,
  output movem_pkg::movem_cmd_t  cmd
);

  movem_pkg::movem_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= movem_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    instr_stall = 1'b1;
    case (state)
      movem_pkg::S_IDLE: begin
        instr_stall = 1'b0;
        if (instr_valid) begin
          cmd.load   = 1'b1;
          state_next = movem_pkg::S_CALC;
        end
      end
      movem_pkg::S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = movem_pkg::S_EMIT;
      end
      movem_pkg::S_EMIT: begin
        if (st.slot_free) begin
          cmd.emit = 1'b1;
          if (st.item_last) begin
            state_next = movem_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = movem_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/movem_dp.sv
// Datapath: decode, effective address, mask walk and output register.
module movem_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  movem_pkg::movem_in_t   instr,
  input  movem_pkg::movem_cmd_t  cmd,
  output movem_pkg::movem_stat_t st,
  output logic                   xfer_valid,
  input  logic                   xfer_stall,
  output movem_pkg::movem_out_t  xfer
);

  // decoded instruction
  logic        bad;
  logic        to_reg;
  logic        lng;
  logic        predec;
  logic        wbv;
  logic [15:0] mask_rem;
  logic [31:0] base;
  logic [31:0] offset;
  logic [31:0] pc4;
  logic [2:0]  ext_bytes;
  logic [31:0] addr;
  logic [31:0] npc;

  // decode of the incoming beat
  logic [2:0]  in_mode, in_reg;
  logic        in_to_reg, in_brief, in_bad;
  logic [31:0] in_pc4, in_idx, in_base, in_offset, in_sx16;
  logic [2:0]  in_ext;

  // mask walk
  logic [3:0]  bit_idx;
  logic [15:0] mask_after;
  logic [31:0] size, addr_dec, addr_step;
  logic        underflow;
  movem_pkg::movem_out_t item;

  always_comb begin
    in_mode   = instr.opcode[5:3];
    in_reg    = instr.opcode[2:0];
    in_to_reg = (instr.opcode & movem_pkg::DIR_TO_REG) != 16'h0;
    in_pc4    = instr.pc + 32'd4;
    in_sx16   = {{16{instr.ext_word1[15]}}, instr.ext_word1};
    in_idx    = ((instr.ext_word1 & movem_pkg::IDX_IS_LONG) != 16'h0) ?
                instr.index_reg_value :
                {{16{instr.index_reg_value[15]}}, instr.index_reg_value[15:0]};
    in_brief  = (in_mode == movem_pkg::MODE_INDEX) ||
                (in_mode == movem_pkg::MODE_EXT && in_reg == movem_pkg::EXT_PC_IDX);
    in_bad    = 1'b0;
    in_base   = instr.addr_reg_value;
    in_offset = 32'd0;
    in_ext    = 3'd0;
    if ((instr.opcode & movem_pkg::MOVEM_MASK) != movem_pkg::MOVEM_MATCH ||
        in_mode == movem_pkg::MODE_DN || in_mode == movem_pkg::MODE_AN) begin
      in_bad = 1'b1;
    end else if (!in_to_reg && in_mode == movem_pkg::MODE_POSTINC) begin
      in_bad = 1'b1;
    end else if (in_to_reg && in_mode == movem_pkg::MODE_PREDEC) begin
      in_bad = 1'b1;
    end else if (in_mode == movem_pkg::MODE_D16) begin
      in_offset = in_sx16;
      in_ext    = 3'd2;
    end else if (in_brief) begin
      if (in_mode == movem_pkg::MODE_EXT && !in_to_reg) begin
        in_bad = 1'b1;
      end else if ((instr.ext_word1 & movem_pkg::IDX_RESERVED) != 16'h0) begin
        in_bad = 1'b1;
      end else begin
        if (in_mode == movem_pkg::MODE_EXT) begin
          in_base = in_pc4;
        end
        in_offset = in_idx + {{24{instr.ext_word1[7]}}, instr.ext_word1[7:0]};
        in_ext    = 3'd2;
      end
    end else if (in_mode == movem_pkg::MODE_EXT) begin
      case (in_reg)
        movem_pkg::EXT_ABS_W: begin
          in_base   = 32'd0;
          in_offset = in_sx16;
          in_ext    = 3'd2;
        end
        movem_pkg::EXT_ABS_L: begin
          in_base   = 32'd0;
          in_offset = {instr.ext_word1, instr.ext_word2};
          in_ext    = 3'd4;
        end
        movem_pkg::EXT_PC_D16: begin
          if (in_to_reg) begin
            in_base   = in_pc4;
            in_offset = in_sx16;
            in_ext    = 3'd2;
          end else begin
            in_bad = 1'b1;
          end
        end
        default: begin
          in_bad = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bad       <= in_bad;
      to_reg    <= in_to_reg;
      lng       <= (instr.opcode & movem_pkg::SIZE_LONG) != 16'h0;
      predec    <= !in_to_reg && in_mode == movem_pkg::MODE_PREDEC;
      wbv       <= (!in_to_reg && in_mode == movem_pkg::MODE_PREDEC) ||
                   (in_to_reg && in_mode == movem_pkg::MODE_POSTINC);
      mask_rem  <= instr.reg_mask;
      base      <= in_base;
      offset    <= in_offset;
      pc4       <= in_pc4;
      ext_bytes <= in_ext;
    end
    if (cmd.calc) begin
      addr <= base + offset;
      npc  <= pc4 + {29'd0, ext_bytes};
    end
    if (cmd.emit) begin
      mask_rem <= mask_after;
      addr     <= addr_step;
    end
  end

  always_comb begin
    bit_idx = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (mask_rem[i]) begin
        bit_idx = 4'(i);
      end
    end
    mask_after = mask_rem & (mask_rem - 16'd1);
    size       = lng ? 32'd4 : 32'd2;
    addr_dec   = addr - size;
    addr_step  = predec ? addr_dec : (addr + size);
    underflow  = predec && (addr < size);

    item = '0;
    if (bad) begin
      item.last   = 1'b1;
      item.status = movem_pkg::ST_ILLEGAL;
    end else if (mask_rem == 16'h0) begin
      // empty list: writeback of the unchanged address
      item.last            = 1'b1;
      item.writeback_valid = wbv;
      item.writeback_value = wbv ? addr : 32'd0;
      item.next_pc         = npc;
    end else if (underflow) begin
      item.last   = 1'b1;
      item.status = movem_pkg::ST_FAULT;
    end else begin
      item.transfer_valid   = 1'b1;
      item.reg_number       = predec ? ~bit_idx : bit_idx;
      item.transfer_address = predec ? addr_dec : addr;
      item.is_write         = !to_reg;
      item.is_long          = lng;
      item.last             = mask_after == 16'h0;
      if (mask_after == 16'h0) begin
        item.writeback_valid = wbv;
        item.writeback_value = wbv ? addr_step : 32'd0;
        item.next_pc         = npc;
      end
    end
  end

  assign st.slot_free = !xfer_valid || !xfer_stall;
  assign st.item_last = item.last;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      xfer_valid <= 1'b0;
    end else if (cmd.emit) begin
      xfer_valid <= 1'b1;
    end else if (!xfer_stall) begin
      xfer_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      xfer <= item;
    end
  end

endmodule

>>> rtl/core/movem_transfer_sequencer.sv
// MOVEM transfer sequencer: one instruction beat in, one beat per register transfer out.
// Order: the instruction is loaded when taken, the address is formed in the calc state,
//   and the first result beat is registered in the emit state once the output has room.
// Throughput: one mask bit per cycle while the output does not stall; result beats are the
//   set mask bits, or one item for an illegal, empty or faulting case.
// Reset (rst, synchronous): controller returns to idle and the output register empties.
module movem_transfer_sequencer (
  input  logic                  clk,
  input  logic                  rst,
  // instruction channel
  input  logic                  instr_valid,
  output logic                  instr_stall,
  input  movem_pkg::movem_in_t  instr,
  // transfer channel
  output logic                  xfer_valid,
  input  logic                  xfer_stall,
  output movem_pkg::movem_out_t xfer
);

  // Controller and datapath talk only through these two groups.
  movem_pkg::movem_cmd_t  cmd;
  movem_pkg::movem_stat_t st;

  // Controller: idle -> address calc -> emit, one beat per mask bit.
  // Stall on the instruction side is high whenever an instruction is in work;
  // a finished beat may still sit in the output register while the next
  // instruction is taken.
  movem_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .instr_valid (instr_valid),
    .instr_stall (instr_stall),
    .st          (st),
    .cmd         (cmd)
  );

  // Datapath: decode and legality at load, base + offset at calc, then the
  // mask walk (reversed register numbering and underflow check for
  // predecrement) feeding the output register.
  movem_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .instr      (instr),
    .cmd        (cmd),
    .st         (st),
    .xfer_valid (xfer_valid),
    .xfer_stall (xfer_stall),
    .xfer       (xfer)
  );

endmodule

>>> tb/movem_transfer_sequencer_tb.sv
// Self-checking testbench for the MOVEM transfer sequencer: random and directed instructions.
module movem_transfer_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 300;  // long receiver hold-off, fills the block
  localparam int RAND_PER_PHASE = 128;

  // Tracks the transfer beats each accepted instruction must produce, in order.
  class xfer_tracker;
    movem_pkg::movem_out_t expected_xfers[$];
    int errors;
    int n_instr, n_beats, n_illegal, n_fault, n_empty;

    function logic [31:0] sext16(logic [15:0] v);
      return {{16{v[15]}}, v};
    endfunction

    function logic [31:0] sext8(logic [7:0] v);
      return {{24{v[7]}}, v};
    endfunction

    function movem_pkg::movem_out_t xfer_beat(logic [3:0] rn, logic [31:0] addr, logic wr,
                                              logic lng);
      movem_pkg::movem_out_t t;
      t = '0;
      t.transfer_valid = 1'b1;
      t.reg_number = rn;
      t.transfer_address = addr;
      t.is_write = wr;
      t.is_long = lng;
      t.status = movem_pkg::ST_RUN;
      return t;
    endfunction

    function movem_pkg::movem_out_t end_beat(logic [1:0] st, logic wbv, logic [31:0] wbval,
                                             logic [31:0] npc);
      movem_pkg::movem_out_t t;
      t = '0;
      t.last = 1'b1;
      t.status = st;
      t.writeback_valid = wbv;
      t.writeback_value = wbval;
      t.next_pc = npc;
      return t;
    endfunction

    function string show(movem_pkg::movem_out_t t);
      return $sformatf("xv=%b reg=%0d addr=%h wr=%b long=%b last=%b st=%0d wb=%b/%h npc=%h",
                       t.transfer_valid, t.reg_number, t.transfer_address, t.is_write,
                       t.is_long, t.last, t.status, t.writeback_valid, t.writeback_value,
                       t.next_pc);
    endfunction

    // Decode, legality check and EA calculation, then one beat per mask bit.
    function void note_instr(movem_pkg::movem_in_t b);
      logic [2:0] mode, rn;
      logic to_reg, lng, predec, bad, wbv;
      logic [31:0] step, npc, ea, base, idx;
      movem_pkg::movem_out_t held;
      bit have_held;
      int i;
      mode = b.opcode[5:3];
      rn = b.opcode[2:0];
      to_reg = (b.opcode & movem_pkg::DIR_TO_REG) != 16'h0;
      lng = (b.opcode & movem_pkg::SIZE_LONG) != 16'h0;
      step = lng ? 32'd4 : 32'd2;
      npc = b.pc + 32'd4;
      ea = '0;
      bad = 1'b0;
      have_held = 0;
      n_instr++;

      if ((b.opcode & movem_pkg::MOVEM_MASK) != movem_pkg::MOVEM_MATCH ||
          mode == movem_pkg::MODE_DN || mode == movem_pkg::MODE_AN)
        bad = 1'b1;
      else if (!to_reg && mode == movem_pkg::MODE_POSTINC)
        bad = 1'b1;
      else if (to_reg && mode == movem_pkg::MODE_PREDEC)
        bad = 1'b1;
      else if (mode == movem_pkg::MODE_IND || mode == movem_pkg::MODE_POSTINC ||
               mode == movem_pkg::MODE_PREDEC)
        ea = b.addr_reg_value;
      else if (mode == movem_pkg::MODE_D16) begin
        ea = b.addr_reg_value + sext16(b.ext_word1);
        npc += 32'd2;
      end else if (mode == movem_pkg::MODE_INDEX ||
                   (mode == movem_pkg::MODE_EXT && rn == movem_pkg::EXT_PC_IDX)) begin
        if (mode == movem_pkg::MODE_EXT && !to_reg)
          bad = 1'b1;
        else if ((b.ext_word1 & movem_pkg::IDX_RESERVED) != 16'h0)
          bad = 1'b1;
        else begin
          base = (mode == movem_pkg::MODE_INDEX) ? b.addr_reg_value : npc;
          idx = ((b.ext_word1 & movem_pkg::IDX_IS_LONG) != 16'h0) ? b.index_reg_value
                                                       : sext16(b.index_reg_value[15:0]);
          ea = base + idx + sext8(b.ext_word1[7:0]);
          npc += 32'd2;
        end
      end else if (rn == movem_pkg::EXT_ABS_W) begin
        ea = sext16(b.ext_word1);
        npc += 32'd2;
      end else if (rn == movem_pkg::EXT_ABS_L) begin
        ea = {b.ext_word1, b.ext_word2};
        npc += 32'd4;
      end else if (rn == movem_pkg::EXT_PC_D16 && to_reg) begin
        ea = npc + sext16(b.ext_word1);
        npc += 32'd2;
      end else
        bad = 1'b1;

      if (bad) begin
        expected_xfers.push_back(end_beat(movem_pkg::ST_ILLEGAL, 1'b0, '0, '0));
        n_illegal++;
        return;
      end

      predec = !to_reg && mode == movem_pkg::MODE_PREDEC;
      // Each beat is held back one step so the final one can take the closing fields.
      for (i = 0; i < 16; i++) begin
        if (b.reg_mask[i]) begin
          if (have_held)
            expected_xfers.push_back(held);
          if (predec) begin
            if (ea < step) begin
              // underflow: beats so far stand, fault item closes without writeback
              expected_xfers.push_back(end_beat(movem_pkg::ST_FAULT, 1'b0, '0, '0));
              n_fault++;
              return;
            end
            ea -= step;
            held = xfer_beat(4'(15 - i), ea, 1'b1, lng);
          end else begin
            held = xfer_beat(4'(i), ea, !to_reg, lng);
            ea += step;
          end
          have_held = 1;
        end
      end

      wbv = predec || (to_reg && mode == movem_pkg::MODE_POSTINC);
      if (!have_held) begin
        expected_xfers.push_back(end_beat(movem_pkg::ST_RUN, wbv, wbv ? ea : 32'h0, npc));
        n_empty++;
      end else begin
        held.last = 1'b1;
        held.writeback_valid = wbv;
        held.writeback_value = wbv ? ea : 32'h0;
        held.next_pc = npc;
        expected_xfers.push_back(held);
      end
    endfunction

    function void check_xfer(movem_pkg::movem_out_t got);
      movem_pkg::movem_out_t want;
      n_beats++;
      if (expected_xfers.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected beat: %s", $realtime, show(got));
        return;
      end
      want = expected_xfers.pop_front();
      if (got.transfer_valid !== want.transfer_valid || got.reg_number !== want.reg_number ||
          got.transfer_address !== want.transfer_address || got.is_write !== want.is_write ||
          got.is_long !== want.is_long || got.last !== want.last ||
          got.status !== want.status || got.writeback_valid !== want.writeback_valid ||
          got.writeback_value !== want.writeback_value || got.next_pc !== want.next_pc) begin
        errors++;
        if (errors <= 10) begin
          $display("[%0t] beat mismatch", $realtime);
          $display("  exp: %s", show(want));
          $display("  got: %s", show(got));
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  instr_valid = 1'b0;
  logic                  instr_stall;
  movem_pkg::movem_in_t  instr = '0;
  logic                  xfer_valid;
  logic                  xfer_stall = 1'b0;
  movem_pkg::movem_out_t xfer;

  xfer_tracker tracker;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;

  movem_transfer_sequencer uut (
    .clk         (clk),
    .rst         (rst),
    .instr_valid (instr_valid),
    .instr_stall (instr_stall),
    .instr       (instr),
    .xfer_valid  (xfer_valid),
    .xfer_stall  (xfer_stall),
    .xfer        (xfer)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: random stall per cycle, or a long hold-off when requested.
  // Changes land on the falling edge so the block sees them settled at the rising edge.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        xfer_stall = 1'b1;
        hold_left--;
      end else
        xfer_stall = ($urandom_range(99) < rx_idle_pct);
    end
  end

  // A result beat moves at a rising edge with valid high and stall low.
  always @(posedge clk) begin
    if (!rst && xfer_valid && !xfer_stall)
      tracker.check_xfer(xfer);
  end

  // Run guard: well past the slowest legal run.
  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [15:0] movem_op(logic to_reg, logic lng, logic [2:0] mode,
                                           logic [2:0] rn);
    return movem_pkg::MOVEM_MATCH | (to_reg ? movem_pkg::DIR_TO_REG : 16'h0) |
           (lng ? movem_pkg::SIZE_LONG : 16'h0) | {10'h0, mode, rn};
  endfunction

  // Offers one instruction beat, with random gaps ahead of it, and holds it until taken.
  task automatic drive_beat(movem_pkg::movem_in_t b);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      instr_valid = 1'b0;
      @(negedge clk);
    end
    instr = b;
    instr_valid = 1'b1;
    do @(posedge clk); while (instr_stall);
    tracker.note_instr(b);
  endtask

  task automatic send(logic [15:0] op, logic [15:0] mask, logic [15:0] e1, logic [15:0] e2,
                      logic [31:0] an, logic [31:0] xn, logic [31:0] pc);
    movem_pkg::movem_in_t b;
    b.opcode = op;
    b.reg_mask = mask;
    b.ext_word1 = e1;
    b.ext_word2 = e2;
    b.addr_reg_value = an;
    b.index_reg_value = xn;
    b.pc = pc;
    drive_beat(b);
  endtask

  // Stop offering and wait until every predicted beat has come out.
  task automatic drain();
    @(negedge clk);
    instr_valid = 1'b0;
    while (tracker.expected_xfers.size() != 0)
      @(posedge clk);
  endtask

  // Mostly legal instructions with random content; the rest is broken modes and noise.
  function automatic movem_pkg::movem_in_t rand_instr();
    movem_pkg::movem_in_t b;
    int kind, pick;
    logic to_reg, lng;
    logic [2:0] mode, rn;
    b.opcode = 16'($urandom);
    b.ext_word1 = 16'($urandom);
    b.ext_word2 = 16'($urandom);
    b.addr_reg_value = $urandom;
    b.index_reg_value = $urandom;
    b.pc = $urandom;
    case ($urandom_range(7))
      0: b.reg_mask = 16'h0001 << $urandom_range(15);
      1: b.reg_mask = 16'hffff;
      2: b.reg_mask = 16'h0000;
      3: b.reg_mask = 16'($urandom & $urandom);
      default: b.reg_mask = 16'($urandom);
    endcase
    kind = $urandom_range(99);
    if (kind < 84) begin
      to_reg = 1'($urandom_range(1));
      lng = 1'($urandom_range(1));
      rn = 3'($urandom_range(7));
      pick = $urandom_range(to_reg ? 7 : 5);
      case (pick)
        0: mode = movem_pkg::MODE_IND;
        1: mode = to_reg ? movem_pkg::MODE_POSTINC : movem_pkg::MODE_PREDEC;
        2: mode = movem_pkg::MODE_D16;
        3: mode = movem_pkg::MODE_INDEX;
        default: mode = movem_pkg::MODE_EXT;
      endcase
      case (pick)
        4: rn = movem_pkg::EXT_ABS_W;
        5: rn = movem_pkg::EXT_ABS_L;
        6: rn = movem_pkg::EXT_PC_D16;
        7: rn = movem_pkg::EXT_PC_IDX;
        default: ;
      endcase
      b.opcode = movem_op(to_reg, lng, mode, rn);
      if (mode == movem_pkg::MODE_INDEX ||
          (mode == movem_pkg::MODE_EXT && rn == movem_pkg::EXT_PC_IDX))
        b.ext_word1 &= ~movem_pkg::IDX_RESERVED;
      // base near zero for predecrement underflow, near the top for postincrement wrap
      if ($urandom_range(3) == 0)
        b.addr_reg_value = to_reg ? 32'hffff_ffff - $urandom_range(80) : $urandom_range(80);
    end else if (kind < 94)
      b.opcode = movem_op(1'($urandom_range(1)), 1'($urandom_range(1)),
                          3'($urandom_range(7)), 3'($urandom_range(7)));
    return b;
  endfunction

  initial begin
    tracker = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Phase 1: sender rarely idles, receiver stalls often.
    tx_idle_pct = 9;
    rx_idle_pct = 62;

    // Directed: each mode, both directions, sizes, and the corner cases.
    send(movem_op(1'b0, 1'b0, movem_pkg::MODE_IND, 3'd0), 16'hffff, 16'h0, 16'h0, $urandom,
         32'h0, $urandom);
    send(movem_op(1'b1, 1'b1, movem_pkg::MODE_POSTINC, 3'd7), 16'h0001, 16'h0, 16'h0,
         32'h0000_1000, 32'h0, 32'h0);
    // full predecrement store, next PC wraps
    send(movem_op(1'b0, 1'b1, movem_pkg::MODE_PREDEC, 3'd7), 16'hffff, 16'h0, 16'h0, 32'h40,
         32'h0, 32'hffff_fffc);
    // underflow after one transfer, and before any transfer
    send(movem_op(1'b0, 1'b1, movem_pkg::MODE_PREDEC, 3'd6), 16'h00ff, 16'h0, 16'h0, 32'd6,
         32'h0, $urandom);
    send(movem_op(1'b0, 1'b0, movem_pkg::MODE_PREDEC, 3'd0), 16'h8000, 16'h0, 16'h0, 32'd0,
         32'h0, $urandom);
    // empty masks: predecrement and postincrement write back, plain indirect does not
    send(movem_op(1'b0, 1'b0, movem_pkg::MODE_PREDEC, 3'd1), 16'h0000, 16'h0, 16'h0, 32'h100,
         32'h0, $urandom);
    send(movem_op(1'b1, 1'b0, movem_pkg::MODE_POSTINC, 3'd2), 16'h0000, 16'h0, 16'h0,
         $urandom, 32'h0, $urandom);
    send(movem_op(1'b1, 1'b1, movem_pkg::MODE_IND, 3'd3), 16'h0000, 16'h0, 16'h0, $urandom,
         32'h0, $urandom);
    send(movem_op(1'b1, 1'b0, movem_pkg::MODE_D16, 3'd4), 16'h5a5a, 16'h8000, 16'h0, 32'h4000,
         32'h0, $urandom);
    send(movem_op(1'b0, 1'b1, movem_pkg::MODE_D16, 3'd5), 16'h0180, 16'h7fff, 16'hffff,
         $urandom, 32'h0, $urandom);
    // brief index: long Xn with most negative byte, word Xn with sign bit set
    send(movem_op(1'b1, 1'b1, movem_pkg::MODE_INDEX, 3'd5), 16'h0f0f, 16'h8880, 16'h0,
         $urandom, 32'hffff_ffff, $urandom);
    send(movem_op(1'b0, 1'b0, movem_pkg::MODE_INDEX, 3'd1), 16'h3000, 16'h007f, 16'h0,
         $urandom, 32'h1234_8000, $urandom);
    send(movem_op(1'b1, 1'b0, movem_pkg::MODE_INDEX, 3'd0), 16'h0001, 16'h0700, 16'h0,
         $urandom, $urandom, $urandom);
    send(movem_op(1'b1, 1'b0, movem_pkg::MODE_EXT, movem_pkg::EXT_ABS_W), 16'h00f0, 16'hffff,
         16'h0, $urandom, 32'h0, $urandom);
    send(movem_op(1'b0, 1'b1, movem_pkg::MODE_EXT, movem_pkg::EXT_ABS_L), 16'hc003, 16'hffff,
         16'hfffe, $urandom, 32'h0, $urandom);
    send(movem_op(1'b1, 1'b1, movem_pkg::MODE_EXT, movem_pkg::EXT_PC_D16), 16'h0810,
         16'h8000, 16'h0, $urandom, 32'h0, $urandom);
    send(movem_op(1'b1, 1'b0, movem_pkg::MODE_EXT, movem_pkg::EXT_PC_IDX), 16'hffff,
         16'hf8ff, 16'h0, $urandom, $urandom, 32'hffff_fff0);
    // PC-relative stores, mode 7 with a reserved register, and a data register mode
    send(movem_op(1'b0, 1'b0, movem_pkg::MODE_EXT, movem_pkg::EXT_PC_D16), 16'h0003,
         16'($urandom), 16'h0, $urandom, 32'h0, $urandom);
    send(movem_op(1'b0, 1'b0, movem_pkg::MODE_EXT, movem_pkg::EXT_PC_IDX), 16'h0003,
         16'h0000, 16'h0, $urandom, 32'h0, $urandom);
    send(movem_op(1'b1, 1'b1, movem_pkg::MODE_EXT, 3'd4), 16'h0003, 16'($urandom), 16'h0,
         $urandom, 32'h0, $urandom);
    send(movem_op(1'b1, 1'b0, movem_pkg::MODE_DN, 3'd0), 16'hffff, 16'h0, 16'h0, $urandom,
         32'h0, $urandom);
    // postincrement store and predecrement load are not allowed
    send(movem_op(1'b0, 1'b0, movem_pkg::MODE_POSTINC, 3'd0), 16'h0001, 16'h0, 16'h0,
         $urandom, 32'h0, $urandom);
    send(movem_op(1'b1, 1'b0, movem_pkg::MODE_PREDEC, 3'd0), 16'h0001, 16'h0, 16'h0,
         $urandom, 32'h0, $urandom);
    send(16'hffff, 16'h0001, 16'h0, 16'h0, $urandom, 32'h0, $urandom);
    // postincrement across the top of the address space
    send(movem_op(1'b1, 1'b1, movem_pkg::MODE_POSTINC, 3'd0), 16'h0007, 16'h0, 16'h0,
         32'hffff_fffe, 32'h0, $urandom);

    repeat (RAND_PER_PHASE) drive_beat(rand_instr());

    // Receiver holds off while the sender keeps offering full-mask stores:
    // the block backs up and stalls the instruction side.
    drain();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    repeat (8)
      send(movem_op(1'b0, 1'b1, movem_pkg::MODE_IND, 3'd2), 16'hffff, 16'h0, 16'h0, $urandom,
           32'h0, $urandom);
    // sender pause: nothing offered until every beat is out
    drain();

    // Phase 2: sender idles often, receiver rarely.
    tx_idle_pct = 62;
    rx_idle_pct = 9;
    repeat (RAND_PER_PHASE) drive_beat(rand_instr());

    // Phase 3: back to back on both sides.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (RAND_PER_PHASE) drive_beat(rand_instr());

    drain();
    // keep clocking to catch stray beats
    repeat (20) @(posedge clk);
    if (tracker.expected_xfers.size() != 0)
      tracker.errors++;

    $display("Ran %0d MOVEM instructions through all modes and directions, %0d beats checked.",
             tracker.n_instr, tracker.n_beats);
    $display("Of those: %0d illegal, %0d predecrement underflows, %0d empty masks; %0d errors.",
             tracker.n_illegal, tracker.n_fault, tracker.n_empty, tracker.errors);
    if (tracker.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/core/movem_pkg.sv
rtl/core/movem_ctrl.sv
rtl/core/movem_dp.sv
rtl/core/movem_transfer_sequencer.sv
tb/movem_transfer_sequencer_tb.sv
